// ===== sv/act_pkg.sv =====
// Shared types and constants for the affine coordinate transform core.
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int COEF_WIDTH_DEF  = 21;

  // radix-2 remainder steps per wrap pipeline stage
  localparam int DIV_STEPS_PER_STAGE = 2;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX   = 3'd6;

  localparam logic [62:0] ROW_A_RST = 63'd2251800350556160;
  localparam logic [62:0] ROW_B_RST = 63'd549755813888;
  localparam logic [62:0] ROW_C_RST = 63'd262144;

  typedef enum logic [1:0] {
    MODE_AFFINE      = 2'd0,
    MODE_AFFINE_WRAP = 2'd1,
    MODE_INVERT      = 2'd2,
    MODE_WRAP        = 2'd3
  } mode_e;

  // control that rides along with one axis through the wrap pipeline
  typedef struct packed {
    logic valid;
    logic en;
  } wrap_ctl_t;

endpackage

`default_nettype wire

// ===== sv/act_wrap.sv =====
// Pipelined floor-modulo of one signed axis value by an unsigned box edge.
`timescale 1ns / 1ps
`default_nettype none

module act_wrap #(
  parameter int RES_W = 27,
  parameter int BOX_W = 21,
  parameter int STEPS = act_pkg::DIV_STEPS_PER_STAGE
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire act_pkg::wrap_ctl_t       ctl_i,
  input  wire logic signed [RES_W-1:0]  val_i,
  input  wire logic        [BOX_W-1:0]  box_i,
  output logic                          valid_o,
  output logic signed      [RES_W-1:0]  val_o
);

  localparam int NSTG  = (RES_W + STEPS - 1) / STEPS;
  localparam int DIV_W = NSTG * STEPS;

  logic [NSTG:0]            vld_q;
  logic [NSTG:0]            en_q;
  logic [NSTG:0]            neg_q;
  logic signed [RES_W-1:0]  org_q [0:NSTG];
  logic [DIV_W-1:0]         mag_q [0:NSTG];
  logic [BOX_W-1:0]         rem_q [0:NSTG];

  logic [RES_W-1:0]         mag_in;
  logic [BOX_W-1:0]         rem_fix;
  logic signed [RES_W-1:0]  val_d;
  logic                     valid_q;
  logic signed [RES_W-1:0]  val_q;

  assign mag_in = val_i[RES_W-1] ? (~val_i + RES_W'(1)) : val_i;

  // entry: split into sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    en_q[0]  <= ctl_i.en;
    neg_q[0] <= val_i[RES_W-1];
    org_q[0] <= val_i;
    mag_q[0] <= DIV_W'(mag_in);
    rem_q[0] <= '0;
  end

  // restoring remainder, STEPS dividend bits per stage, MSB first
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic [BOX_W-1:0] rem_c;
    logic [DIV_W-1:0] mag_c;
    logic [BOX_W:0]   trial_c;

    always_comb begin
      rem_c   = rem_q[k-1];
      mag_c   = mag_q[k-1];
      trial_c = '0;
      for (int s = 0; s < STEPS; s++) begin
        trial_c = {rem_c, mag_c[DIV_W-1]};
        mag_c   = mag_c << 1;
        if (trial_c >= {1'b0, box_i}) begin
          trial_c = trial_c - {1'b0, box_i};
        end
        rem_c = trial_c[BOX_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      en_q[k]  <= en_q[k-1];
      neg_q[k] <= neg_q[k-1];
      org_q[k] <= org_q[k-1];
      mag_q[k] <= mag_c;
      rem_q[k] <= rem_c;
    end
  end

  // truncated remainder of a negative value folds back to box - r
  assign rem_fix = (neg_q[NSTG] && (rem_q[NSTG] != '0)) ? (box_i - rem_q[NSTG])
                                                        : rem_q[NSTG];
  assign val_d   = en_q[NSTG] ? $signed(RES_W'(rem_fix)) : org_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;

endmodule

`default_nettype wire

// ===== sv/affine_coordinate_transform_core.sv =====
// Top level: pipelined 3D affine transform, point inversion and periodic wrap.
// The datapath stages, the wrap remainder pipeline and the output register lie between the accepting edge and done_o.
// Throughput: one point per cycle; busy_o never rises and done_o cannot be held off.
// The wrap remainder pipeline (two bits per stage) sets the depth.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module affine_coordinate_transform_core #(
  parameter int COORD_WIDTH = act_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = act_pkg::COEF_WIDTH_DEF,
  localparam int CFG_W      = 3 * ((COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH)
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  output logic                                busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]  in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  in_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]  in_z_i,
  input  wire                                 cfg_we_i,
  input  wire logic [act_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]               cfg_wdata_i,
  output logic                                done_o,
  output logic signed [COORD_WIDTH-1:0]       out_x_o,
  output logic signed [COORD_WIDTH-1:0]       out_y_o,
  output logic signed [COORD_WIDTH-1:0]       out_z_o,
  output logic                                saturated_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int KW     = COEF_WIDTH;
  localparam int FRAC   = KW - 3;
  localparam int DIFF_W = CW + 1;
  localparam int PROD_W = KW + DIFF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RES_W  = ACC_W - FRAC;
  localparam int SPS    = act_pkg::DIV_STEPS_PER_STAGE;
  localparam int NSTG   = (RES_W + SPS - 1) / SPS;
  localparam int LAT    = NSTG + 7;

  localparam logic [ACC_W-1:0] HALF_LSB = {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic [CW-1:0]    OUT_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]    OUT_MIN  = {1'b1, {(CW-1){1'b0}}};

  // ---------------- configuration registers ----------------
  act_pkg::mode_e     mode_q;
  logic [3*KW-1:0]    row_q [3];
  logic [3*CW-1:0]    pivot_q;
  logic [3*CW-1:0]    trans_q;
  logic [3*CW-1:0]    box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= act_pkg::MODE_AFFINE;
      row_q[0] <= act_pkg::ROW_A_RST[3*KW-1:0];
      row_q[1] <= act_pkg::ROW_B_RST[3*KW-1:0];
      row_q[2] <= act_pkg::ROW_C_RST[3*KW-1:0];
      pivot_q  <= '0;
      trans_q  <= '0;
      box_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        act_pkg::REG_MODE:  mode_q   <= act_pkg::mode_e'(cfg_wdata_i[1:0]);
        act_pkg::REG_ROW_A: row_q[0] <= cfg_wdata_i[3*KW-1:0];
        act_pkg::REG_ROW_B: row_q[1] <= cfg_wdata_i[3*KW-1:0];
        act_pkg::REG_ROW_C: row_q[2] <= cfg_wdata_i[3*KW-1:0];
        act_pkg::REG_PIVOT: pivot_q  <= cfg_wdata_i[3*CW-1:0];
        act_pkg::REG_TRANS: trans_q  <= cfg_wdata_i[3*CW-1:0];
        act_pkg::REG_BOX:   box_q    <= cfg_wdata_i[3*CW-1:0];
        default: ;
      endcase
    end
  end

  // field 0 (x) sits in the high bits
  logic signed [KW-1:0] coef_w  [3][3];
  logic signed [CW-1:0] piv_w   [3];
  logic signed [CW-1:0] tr_w    [3];
  logic        [CW-1:0] box_w   [3];
  logic signed [CW-1:0] in_p    [3];

  for (genvar i = 0; i < 3; i++) begin : g_fields
    for (genvar j = 0; j < 3; j++) begin : g_coef
      assign coef_w[i][j] = $signed(row_q[i][(2-j)*KW +: KW]);
    end
    assign piv_w[i] = $signed(pivot_q[(2-i)*CW +: CW]);
    assign tr_w[i]  = $signed(trans_q[(2-i)*CW +: CW]);
    assign box_w[i] = box_q[(2-i)*CW +: CW];
  end

  assign in_p[0] = in_x_i;
  assign in_p[1] = in_y_i;
  assign in_p[2] = in_z_i;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- pipeline ----------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  logic signed [CW-1:0]     s1_p_q    [3];
  logic signed [DIFF_W-1:0] s1_diff_q [3];
  logic signed [CW-1:0]     s2_p_q    [3];
  logic signed [PROD_W-1:0] s2_prod_q [3][3];
  logic signed [CW-1:0]     s3_p_q    [3];
  logic signed [ACC_W-1:0]  s3_acc_q  [3];
  logic signed [RES_W-1:0]  s4_res_q  [3];
  logic [2:0]               s4_en_q;

  logic signed [RES_W-1:0]  res_d     [3];
  logic [2:0]               en_d;
  logic [2:0]               w_valid;
  logic signed [RES_W-1:0]  w_val     [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [RES_W-1:0] piv_ext;
    logic signed [RES_W-1:0] tr_ext;
    logic signed [RES_W-1:0] p_ext;
    logic signed [RES_W-1:0] affine;
    logic signed [RES_W-1:0] invert;
    act_pkg::wrap_ctl_t      ctl;

    // stage 1: offset from pivot
    always_ff @(posedge clk_i) begin
      s1_p_q[i]    <= in_p[i];
      s1_diff_q[i] <= $signed({in_p[i][CW-1], in_p[i]}) - $signed({piv_w[i][CW-1], piv_w[i]});
    end

    // stage 2: one product per matrix entry
    always_ff @(posedge clk_i) begin
      s2_p_q[i] <= s1_p_q[i];
      for (int j = 0; j < 3; j++) begin
        s2_prod_q[i][j] <= coef_w[i][j] * s1_diff_q[j];
      end
    end

    // stage 3: row sum plus half an output LSB
    always_ff @(posedge clk_i) begin
      s3_p_q[i]   <= s2_p_q[i];
      s3_acc_q[i] <= $signed({{2{s2_prod_q[i][0][PROD_W-1]}}, s2_prod_q[i][0]})
                   + $signed({{2{s2_prod_q[i][1][PROD_W-1]}}, s2_prod_q[i][1]})
                   + $signed({{2{s2_prod_q[i][2][PROD_W-1]}}, s2_prod_q[i][2]})
                   + $signed(HALF_LSB);
    end

    // stage 4: floor by dropping fraction bits, then offsets and mode select
    assign piv_ext = $signed({{(RES_W-CW){piv_w[i][CW-1]}}, piv_w[i]});
    assign tr_ext  = $signed({{(RES_W-CW){tr_w[i][CW-1]}}, tr_w[i]});
    assign p_ext   = $signed({{(RES_W-CW){s3_p_q[i][CW-1]}}, s3_p_q[i]});
    assign affine  = $signed(s3_acc_q[i][ACC_W-1:FRAC]) + piv_ext + tr_ext;
    assign invert  = $signed({piv_ext[RES_W-2:0], 1'b0}) - p_ext;

    always_comb begin
      unique case (mode_q)
        act_pkg::MODE_AFFINE,
        act_pkg::MODE_AFFINE_WRAP: res_d[i] = affine;
        act_pkg::MODE_INVERT:      res_d[i] = invert;
        act_pkg::MODE_WRAP:        res_d[i] = p_ext;
        default:                   res_d[i] = p_ext;
      endcase
    end

    assign en_d[i] = ((mode_q == act_pkg::MODE_AFFINE_WRAP) || (mode_q == act_pkg::MODE_WRAP))
                     && (box_w[i] != '0);

    always_ff @(posedge clk_i) begin
      s4_res_q[i] <= res_d[i];
      s4_en_q[i]  <= en_d[i];
    end

    assign ctl.valid = s4_valid_q;
    assign ctl.en    = s4_en_q[i];

    act_wrap #(
      .RES_W (RES_W),
      .BOX_W (CW),
      .STEPS (SPS)
    ) u_wrap (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .val_i   (s4_res_q[i]),
      .box_i   (box_w[i]),
      .valid_o (w_valid[i]),
      .val_o   (w_val[i])
    );
  end

  // ---------------- clamp and output beat ----------------
  logic [CW-1:0] clamp_d [3];
  logic [2:0]    ovf;

  for (genvar i = 0; i < 3; i++) begin : g_clamp
    // fits when all bits from the output sign upward agree
    assign ovf[i]     = !((&w_val[i][RES_W-1:CW-1]) || !(|w_val[i][RES_W-1:CW-1]));
    assign clamp_d[i] = ovf[i] ? (w_val[i][RES_W-1] ? OUT_MIN : OUT_MAX) : w_val[i][CW-1:0];
  end

  logic                 done_q;
  logic signed [CW-1:0] out_q [3];
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= &w_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= $signed(clamp_d[i]);
    end
    sat_q <= |ovf;
  end

  assign done_o      = done_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign saturated_o = sat_q;

  // ---------------- assertions ----------------
  a_accept_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("accepted beat did not complete after the pipeline latency");

  a_done_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result beat without a matching accepted beat");

  a_sat_is_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      ((out_x_o == $signed(OUT_MAX)) || (out_x_o == $signed(OUT_MIN)) ||
       (out_y_o == $signed(OUT_MAX)) || (out_y_o == $signed(OUT_MIN)) ||
       (out_z_o == $signed(OUT_MAX)) || (out_z_o == $signed(OUT_MIN))))
    else $error("saturation flagged but no axis sits at a range limit");

endmodule

`default_nettype wire

// ===== dv/tb_affine_coordinate_transform_core.sv =====
// Self-checking testbench for the affine coordinate transform core.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [act_pkg::COORD_WIDTH_DEF-1:0] x;
  logic signed [act_pkg::COORD_WIDTH_DEF-1:0] y;
  logic signed [act_pkg::COORD_WIDTH_DEF-1:0] z;
  logic                                       sat;
} point_res_t;

class point_transform_model;
  localparam int CW    = act_pkg::COORD_WIDTH_DEF;
  localparam int KW    = act_pkg::COEF_WIDTH_DEF;
  localparam int KFRAC = KW - 3;

  act_pkg::mode_e    mode;
  logic [3*KW-1:0]   rows [3];
  logic [3*CW-1:0]   pivot;
  logic [3*CW-1:0]   shift;
  logic [3*CW-1:0]   box;
  point_res_t        expected_points [$];
  int                mismatches;

  function new();
    mode       = act_pkg::MODE_AFFINE;
    rows[0]    = act_pkg::ROW_A_RST;
    rows[1]    = act_pkg::ROW_B_RST;
    rows[2]    = act_pkg::ROW_C_RST;
    pivot      = '0;
    shift      = '0;
    box        = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [act_pkg::CFG_IDX_W-1:0] idx, logic [62:0] data);
    case (idx)
      act_pkg::REG_MODE:  mode = act_pkg::mode_e'(data[1:0]);
      act_pkg::REG_ROW_A: rows[0] = data[3*KW-1:0];
      act_pkg::REG_ROW_B: rows[1] = data[3*KW-1:0];
      act_pkg::REG_ROW_C: rows[2] = data[3*KW-1:0];
      act_pkg::REG_PIVOT: pivot = data[3*CW-1:0];
      act_pkg::REG_TRANS: shift = data[3*CW-1:0];
      act_pkg::REG_BOX:   box = data[3*CW-1:0];
      default: ;
    endcase
  endfunction

  // x sits in the top field of every packed triple
  function longint coord_of(logic [3*CW-1:0] r, int k);
    logic signed [CW-1:0] f;
    f = r[(2-k)*CW +: CW];
    return longint'(f);
  endfunction

  function longint coef_of(int row, int col);
    logic signed [KW-1:0] f;
    f = rows[row][(2-col)*KW +: KW];
    return longint'(f);
  endfunction

  function longint floor_wrap(longint v, int k);
    longint b;
    longint r;
    b = longint'({1'b0, box[(2-k)*CW +: CW]});
    if (b == 0) return v;
    r = v % b;
    if (r < 0) r += b;
    return r;
  endfunction

  function point_res_t transform_point(logic signed [CW-1:0] px, py, pz);
    longint     p [3];
    longint     res [3];
    longint     acc;
    longint     hi;
    longint     lo;
    point_res_t r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      case (mode)
        act_pkg::MODE_AFFINE, act_pkg::MODE_AFFINE_WRAP: begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += coef_of(i, j) * (p[j] - coord_of(pivot, j));
          // round half up onto the coordinate grid
          acc += longint'(1) << (KFRAC - 1);
          res[i] = (acc >>> KFRAC) + coord_of(pivot, i) + coord_of(shift, i);
          if (mode == act_pkg::MODE_AFFINE_WRAP) res[i] = floor_wrap(res[i], i);
        end
        act_pkg::MODE_INVERT: res[i] = 2 * coord_of(pivot, i) - p[i];
        default:              res[i] = floor_wrap(p[i], i);
      endcase
    end
    hi    = (longint'(1) << (CW - 1)) - 1;
    lo    = -hi - 1;
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (res[i] > hi) begin
        res[i] = hi;
        r.sat  = 1'b1;
      end
      if (res[i] < lo) begin
        res[i] = lo;
        r.sat  = 1'b1;
      end
    end
    r.x = res[0][CW-1:0];
    r.y = res[1][CW-1:0];
    r.z = res[2][CW-1:0];
    return r;
  endfunction

  function void note_point(logic signed [CW-1:0] px, py, pz);
    expected_points.push_back(transform_point(px, py, pz));
  endfunction

  function int pending();
    return expected_points.size();
  endfunction

  function void check_point(point_res_t got);
    point_res_t want;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with nothing predicted: x=%0d y=%0d z=%0d sat=%0b",
                 $time, got.x, got.y, got.z, got.sat);
      return;
    end
    want = expected_points.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.sat !== want.sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                 $time, want.x, want.y, want.z, want.sat, got.x, got.y, got.z, got.sat);
    end
  endfunction
endclass

module tb_affine_coordinate_transform_core;

  localparam int CW          = act_pkg::COORD_WIDTH_DEF;
  localparam int KW          = act_pkg::COEF_WIDTH_DEF;
  localparam int TW          = 3 * CW;
  localparam int PIPE_LAT    = 21;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic signed [CW-1:0] C_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]        BOX_MAX = '1;
  localparam logic signed [KW-1:0] K_MAX   = {1'b0, {(KW-1){1'b1}}};
  localparam logic signed [KW-1:0] K_MIN   = {1'b1, {(KW-1){1'b0}}};
  localparam logic signed [KW-1:0] K_ONE   = KW'(1 << (KW - 3));
  localparam logic signed [KW-1:0] K_HALF  = KW'(1 << (KW - 4));
  // no register lives at this index; writes to it must be dropped
  localparam logic [act_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic signed [CW-1:0]            in_x_i;
  logic signed [CW-1:0]            in_y_i;
  logic signed [CW-1:0]            in_z_i;
  logic                            cfg_we_i;
  logic [act_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [TW-1:0]                   cfg_wdata_i;
  logic                            done_o;
  logic signed [CW-1:0]            out_x_o;
  logic signed [CW-1:0]            out_y_o;
  logic signed [CW-1:0]            out_z_o;
  logic                            saturated_o;
  int                              cycle_count;

  point_transform_model xform = new();

  affine_coordinate_transform_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      xform.check_point({out_x_o, out_y_o, out_z_o, saturated_o});
  end

  function automatic logic [TW-1:0] pack3(logic [CW-1:0] a, logic [CW-1:0] b,
                                          logic [CW-1:0] c);
    return {a, b, c};
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(bit narrow);
    logic [31:0] r;
    r = $urandom();
    if (narrow) return CW'($signed(r[16:0]));
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return CW'($signed(r[10:0]));
      default: return r[CW-1:0];
    endcase
  endfunction

  function automatic logic signed [KW-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return K_MAX;
      1:       return K_MIN;
      2:       return '0;
      3:       return r[KW-1:0];
      default: return KW'($signed(r[KW-3:0]));  // within about +-1.0
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_box();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return BOX_MAX;
      2:       return CW'(1);
      3:       return r[CW-1:0];
      default: return CW'(r[12:0]);
    endcase
  endfunction

  // caller lowers cfg_we_i after the last write of a batch
  task automatic write_reg(logic [act_pkg::CFG_IDX_W-1:0] idx, logic [TW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    xform.write_reg(idx, data);
  endtask

  task automatic load_setting(act_pkg::mode_e m, logic [TW-1:0] ra, logic [TW-1:0] rb,
                              logic [TW-1:0] rc, logic [TW-1:0] piv,
                              logic [TW-1:0] trn, logic [TW-1:0] bx);
    logic [TW-1:0] mode_word;
    mode_word      = TW'({$urandom(), $urandom()});
    mode_word[1:0] = m;
    write_reg(act_pkg::REG_ROW_A, ra);
    write_reg(act_pkg::REG_ROW_B, rb);
    write_reg(act_pkg::REG_ROW_C, rc);
    write_reg(act_pkg::REG_PIVOT, piv);
    write_reg(act_pkg::REG_TRANS, trn);
    write_reg(act_pkg::REG_BOX, bx);
    write_reg(REG_NONE, TW'({$urandom(), $urandom()}));
    write_reg(act_pkg::REG_MODE, mode_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // leaves start_i high; the caller decides whether the next beat follows directly
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    start_i <= 1'b1;
    in_x_i  <= x;
    in_y_i  <= y;
    in_z_i  <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    xform.note_point(x, y, z);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (xform.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_points(int count, bit narrow);
    int left_in_burst;
    left_in_burst = 0;
    for (int i = 0; i < count; i++) begin
      if (left_in_burst == 0)
        left_in_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
      send_point(pick_coord(narrow), pick_coord(narrow), pick_coord(narrow));
      left_in_burst--;
      if (left_in_burst == 0 || i == count - 1) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic [TW-1:0] ra;
    logic [TW-1:0] rb;
    logic [TW-1:0] rc;
    bit            narrow;
    cycle_count = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_x_i      = '0;
    in_y_i      = '0;
    in_z_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults after reset
    send_point(0, 0, 0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, 1);
    drain();

    // half coefficients put the rounding exactly on ties
    load_setting(act_pkg::MODE_AFFINE, pack3(K_HALF, 0, 0), pack3(0, -K_HALF, 0),
                 pack3(0, 0, K_ONE), '0, pack3(5, -5, 0), '0);
    send_point(1, 1, 3);
    send_point(-1, -1, -3);
    send_point(3, -3, 0);
    drain();

    // wrap after identity: finite box, disabled axis, box past the signed max
    load_setting(act_pkg::MODE_AFFINE_WRAP, pack3(K_ONE, 0, 0), pack3(0, K_ONE, 0),
                 pack3(0, 0, K_ONE), pack3(100, -100, 0), '0, pack3(1000, 0, BOX_MAX));
    send_point(-1, 5, 7);
    send_point(999, 1000, C_MIN);
    send_point(1000, -5, C_MAX);
    send_point(C_MIN, C_MAX, -1);
    drain();

    load_setting(act_pkg::MODE_INVERT, '0, '0, '0, pack3(C_MAX, C_MIN, 0), '0, '0);
    send_point(C_MIN, C_MAX, 0);
    send_point(0, 0, 5);
    send_point(C_MAX, C_MIN, C_MIN);
    drain();

    load_setting(act_pkg::MODE_WRAP, '0, '0, '0, '0, '0, pack3(1, 0, BOX_MAX));
    send_point(C_MIN, C_MAX, -1);
    send_point(5, -7, C_MAX);
    send_point(0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        ra = pack3(K_MAX, K_MAX, K_MAX);
        rb = ra;
        rc = ra;
      end else if (ph == 1) begin
        ra = pack3(K_MIN, K_MIN, K_MIN);
        rb = ra;
        rc = ra;
      end else begin
        ra = pack3(pick_coef(), pick_coef(), pick_coef());
        rb = pack3(pick_coef(), pick_coef(), pick_coef());
        rc = pack3(pick_coef(), pick_coef(), pick_coef());
      end
      narrow = (ph >= 2) && ($urandom_range(0, 1) == 1);
      load_setting(act_pkg::mode_e'(ph % 4), ra, rb, rc,
                   pack3(pick_coord(narrow), pick_coord(narrow), pick_coord(narrow)),
                   pack3(pick_coord(narrow), pick_coord(narrow), pick_coord(narrow)),
                   pack3(pick_box(), pick_box(), pick_box()));
      run_points(50, narrow);
      drain();
    end

    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (xform.mismatches == 0 && xform.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
